[rtl/core/kts_pkg.sv]
// ----------------------------------------------------------------------------
// kts_pkg: shared definitions for the keyed table leftmost search
// Operation codes, field widths, parameter defaults and the compare result.
// ----------------------------------------------------------------------------
package kts_pkg;

	// Field widths of one beat
	localparam int KEY_W   = 64;
	localparam int INDEX_W = 6;
	localparam int OP_W    = 2;

	// Parameter defaults
	localparam int DEPTH_DEF     = 64;
	localparam int KEY_BYTES_DEF = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH  = 2'd1;
	localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;

	// Result of the shared key compare
	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

[rtl/core/kts_ram.sv]
// ----------------------------------------------------------------------------
// kts_ram: generic single-write, single-read RAM
// One write port and one read port per cycle; read data is registered.
// ----------------------------------------------------------------------------
module kts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/kts_cmp.sv]
// ----------------------------------------------------------------------------
// kts_cmp: shared key compare unit
// Unsigned compare of a stored probe key against the search key.
// ----------------------------------------------------------------------------
module kts_cmp #(
	parameter int KW = 64
) (
	input  logic [KW-1:0]     probe,
	input  logic [KW-1:0]     ref_key,
	output kts_pkg::cmp_res_t res
);
	import kts_pkg::*;

	// Order keys as a byte-wise string compare would
	always_comb begin
		res.eq = (probe == ref_key);
		res.gt = (probe > ref_key);
	end

endmodule

[rtl/core/keyed_table_leftmost_search.sv]
// ----------------------------------------------------------------------------
// keyed_table_leftmost_search: key table with append, leftmost search, reverse
// Append and unused codes answer in the cycle after accept; search does one
//   RAM read and one shared compare per probe, probes <= floor(log2(fill)) + 1
//   (7 at 64 entries); reverse swaps floor(fill / 2) pairs through R_RD_HI,
//   R_WR_LO and R_WR_HI. Start is ignored while busy; busy drops with the
//   result strobe and the receiver cannot stall. Reset clears all registers, not the RAM.
// ----------------------------------------------------------------------------
module keyed_table_leftmost_search #(
	parameter int DEPTH     = kts_pkg::DEPTH_DEF,
	parameter int KEY_BYTES = kts_pkg::KEY_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [kts_pkg::OP_W-1:0]    op,
	input  logic [kts_pkg::KEY_W-1:0]   key,
	output logic                        done,
	output logic                        found,
	output logic [kts_pkg::INDEX_W-1:0] index,
	output logic                        status
);
	import kts_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int KW = 8 * KEY_BYTES;
	localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);
	localparam logic [AW:0] TWO_C   = (AW + 1)'(2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		R_RD_HI,
		R_WR_LO,
		R_WR_HI
	} state_t;

	state_t state_q;

	logic [AW:0]    fill_q;
	logic [AW:0]    lo_q;
	logic [AW:0]    hix_q;
	logic [AW-1:0]  mid_q;
	logic           hit_q;
	logic [AW-1:0]  where_q;
	logic [KW-1:0]  key_q;
	logic [KW-1:0]  tmp_q;
	logic           done_q;
	logic           found_q;
	logic [INDEX_W-1:0] index_q;
	logic           status_q;

	logic [AW:0]    lo_n;
	logic [AW:0]    hix_n;
	logic           hit_n;
	logic [AW-1:0]  where_n;
	logic [AW+1:0]  sum_w;
	logic [AW-1:0]  mid_n;
	logic [AW:0]    lo_inc;
	logic [AW:0]    hix_dec;
	logic           full;

	logic           we;
	logic [AW-1:0]  wr_addr;
	logic [KW-1:0]  wr_data;
	logic [AW-1:0]  rd_addr;
	logic [KW-1:0]  rd_data;
	cmp_res_t       cmp_res;

	function automatic logic [INDEX_W-1:0] to_index(input logic [AW-1:0] a);
		logic [AW+INDEX_W-1:0] w;
		w = {{INDEX_W{1'b0}}, a};
		return w[INDEX_W-1:0];
	endfunction

	kts_ram #(
		.WIDTH (KW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kts_cmp #(
		.KW (KW)
	) u_cmp (
		.probe   (rd_data),
		.ref_key (key_q),
		.res     (cmp_res)
	);

	assign full    = (fill_q == DEPTH_C);
	assign busy    = (state_q != S_IDLE);
	assign lo_inc  = lo_q + 1'b1;
	assign hix_dec = hix_q - 1'b1;

	// Narrow the search window from the probe just read; drive the write port
	always_comb begin
		lo_n    = lo_q;
		hix_n   = hix_q;
		hit_n   = hit_q;
		where_n = where_q;
		we      = 1'b0;
		wr_addr = fill_q[AW-1:0];
		wr_data = key[KW-1:0];
		unique case (state_q)
			S_IDLE: begin
				lo_n    = '0;
				hix_n   = fill_q;
				hit_n   = 1'b0;
				where_n = '0;
				we      = start && (op == OP_APPEND) && !full;
			end
			S_SRCH: begin
				if (cmp_res.eq) begin
					hit_n   = 1'b1;
					where_n = mid_q;
					hix_n   = {1'b0, mid_q};
				end else if (cmp_res.gt) begin
					hix_n = {1'b0, mid_q};
				end else begin
					lo_n = {1'b0, mid_q} + 1'b1;
				end
			end
			R_WR_LO: begin
				we      = 1'b1;
				wr_addr = lo_q[AW-1:0];
				wr_data = rd_data;
			end
			R_WR_HI: begin
				we      = 1'b1;
				wr_addr = hix_q[AW-1:0];
				wr_data = tmp_q;
			end
			default: begin
			end
		endcase
	end

	// Midpoint of the inclusive window [lo, hix - 1]
	assign sum_w = (AW + 2)'(lo_n) + (AW + 2)'(hix_n) - (AW + 2)'(1);
	assign mid_n = sum_w[AW:1];

	// Select the read address
	always_comb begin
		rd_addr = mid_n;
		case (state_q)
			S_IDLE: begin
				if (op == OP_REVERSE) begin
					rd_addr = '0;
				end
			end
			R_RD_HI: rd_addr = hix_q[AW-1:0];
			R_WR_HI: rd_addr = lo_inc[AW-1:0];
			default: rd_addr = mid_n;
		endcase
	end

	// Sequencer, table state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			lo_q     <= '0;
			hix_q    <= '0;
			mid_q    <= '0;
			hit_q    <= 1'b0;
			where_q  <= '0;
			key_q    <= '0;
			tmp_q    <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			index_q  <= '0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q    <= key[KW-1:0];
						lo_q     <= lo_n;
						hix_q    <= hix_n;
						hit_q    <= hit_n;
						where_q  <= where_n;
						mid_q    <= mid_n;
						found_q  <= 1'b0;
						index_q  <= '0;
						status_q <= 1'b0;
						case (op)
							OP_APPEND: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= 1'b1;
								end else begin
									fill_q  <= fill_q + 1'b1;
									index_q <= to_index(fill_q[AW-1:0]);
								end
							end
							OP_SEARCH: begin
								if (fill_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_SRCH;
								end
							end
							OP_REVERSE: begin
								if (fill_q < TWO_C) begin
									done_q <= 1'b1;
								end else begin
									lo_q    <= '0;
									hix_q   <= fill_q - 1'b1;
									state_q <= R_RD_HI;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SRCH: begin
					lo_q    <= lo_n;
					hix_q   <= hix_n;
					hit_q   <= hit_n;
					where_q <= where_n;
					mid_q   <= mid_n;
					if (!(lo_n < hix_n)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						found_q <= hit_n;
						index_q <= hit_n ? to_index(where_n) : '0;
					end
				end
				R_RD_HI: begin
					// Hold the low entry while the high one is read
					tmp_q   <= rd_data;
					state_q <= R_WR_LO;
				end
				R_WR_LO: begin
					state_q <= R_WR_HI;
				end
				R_WR_HI: begin
					// Advance both ends toward the middle
					lo_q  <= lo_inc;
					hix_q <= hix_dec;
					if (lo_inc < hix_dec) begin
						state_q <= R_RD_HI;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign found  = found_q;
	assign index  = index_q;
	assign status = status_q;

`ifndef ASSERT_OFF
	// Fill count never passes the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count above table size");

	// A probe never reads past the filled entries
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> ({1'b0, mid_q} < fill_q))
		else $error("search probe outside filled entries");

	// An accepted append with room grows the table by one
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_APPEND) && !full) |=>
		(fill_q == $past(fill_q) + 1'b1))
		else $error("append did not advance fill count");

	// No result beat while an operation is still running
	a_no_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done_q)
		else $error("result beat while busy");

	// A refused append never reports a hit
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(status_q && found_q))
		else $error("full status together with found");
`endif

endmodule
